### rtl/eflba_pkg.sv
`default_nettype none

package eflba_pkg;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'd1;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_REINIT = 2'd2;

	localparam logic [1:0] STAT_OK           = 2'd0;
	localparam logic [1:0] STAT_NO_BLOCK     = 2'd1;
	localparam logic [1:0] STAT_INVALID_FREE = 2'd2;

	localparam logic [7:0] BLOCK_COUNT_RST = 8'd255;
	localparam logic [8:0] BLOCK_SIZE_RST  = 9'd16;
	localparam logic [8:0] BLOCK_SIZE_MAX  = 9'd256;

endpackage

`default_nettype wire

### rtl/embedded_free_list_block_allocator_core.sv
// a result is registered when ST_EXEC commits; a held earlier result stalls it
// one item at a time, as ST_EXEC uses the registered read of the link memory
// reinit needs no clearing pass: per-entry valid bits restore the i+1 links at once
// reset: asynchronous, control and valid bits clear at once, no clearing pass,
// the block accepts an item in the first cycle after reset is released
`default_nettype none

module embedded_free_list_block_allocator_core
	import eflba_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = 255
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            operation,
	input  wire logic [7:0]            block_index,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 status,
	output logic [7:0]                 granted_index,
	output logic [15:0]                byte_offset,
	output logic [7:0]                 blocks_free
);

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam logic [7:0]  MAX_B = 8'(MAX_BLOCKS);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [7:0] block_count_q;
	logic [8:0] block_size_q;
	logic [7:0] head_q;
	logic [7:0] free_q;
	logic [7:0] active_q;
	logic [1:0] op_q;
	logic [7:0] idx_q;

	logic [7:0]           link_mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] link_vld_q;
	logic [7:0]           link_rd_q;
	logic                 link_rd_vld_q;

	logic       in_beat;
	logic       exec_go;
	logic       head_in_rng;
	logic [7:0] new_active;
	logic [8:0] eff_size;
	logic [7:0] link_val;
	logic [16:0] offset_full;

	logic [1:0] res_status;
	logic [7:0] res_grant;
	logic [7:0] res_free;
	logic [7:0] res_head;
	logic       do_free;
	logic       do_reinit;

	logic       out_valid_q;
	logic [1:0] status_q;
	logic [7:0] grant_q;
	logic [15:0] offset_q;
	logic [7:0] blocks_free_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_beat     = in_valid && in_ready;
	assign exec_go     = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign head_in_rng = (head_q < MAX_B);

	always_comb begin
		if (block_count_q == 8'd0) begin
			new_active = 8'd1;
		end else if (block_count_q > MAX_B) begin
			new_active = MAX_B;
		end else begin
			new_active = block_count_q;
		end
		if (block_size_q == 9'd0) begin
			eff_size = 9'd1;
		end else if (block_size_q > BLOCK_SIZE_MAX) begin
			eff_size = BLOCK_SIZE_MAX;
		end else begin
			eff_size = block_size_q;
		end
	end

	// an entry never written since reset or reinit holds its own index plus one
	assign link_val = link_rd_vld_q ? link_rd_q : 8'(head_q + 8'd1);

	always_comb begin
		res_status = STAT_OK;
		res_grant  = 8'd0;
		res_free   = free_q;
		res_head   = head_q;
		do_free    = 1'b0;
		do_reinit  = 1'b0;
		case (op_q)
			OP_ALLOC: begin
				if (free_q == 8'd0 || head_q >= active_q) begin
					res_status = STAT_NO_BLOCK;
				end else begin
					res_grant = head_q;
					res_head  = link_val;
					res_free  = 8'(free_q - 8'd1);
				end
			end
			OP_FREE: begin
				if (idx_q >= active_q || free_q >= active_q) begin
					res_status = STAT_INVALID_FREE;
				end else begin
					do_free  = 1'b1;
					res_head = idx_q;
					res_free = 8'(free_q + 8'd1);
				end
			end
			OP_REINIT: begin
				do_reinit = 1'b1;
				res_head  = 8'd0;
				res_free  = new_active;
			end
			default: begin
			end
		endcase
	end

	assign offset_full = 17'(res_grant) * 17'(eff_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RST;
			block_size_q  <= BLOCK_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_BLOCK_COUNT: block_count_q <= cfg_wdata[7:0];
				CFG_BLOCK_SIZE:  block_size_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= 8'd0;
			free_q   <= MAX_B;
			active_q <= MAX_B;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
						head_q  <= res_head;
						free_q  <= res_free;
						if (do_reinit) begin
							active_q <= new_active;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q  <= operation;
			idx_q <= block_index;
		end
	end

	// link memory: read the head on accept, write the pushed link on commit
	always_ff @(posedge clk) begin
		if (exec_go && do_free) begin
			link_mem[idx_q[IDX_W-1:0]] <= head_q;
		end
		if (in_beat && head_in_rng) begin
			link_rd_q <= link_mem[head_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q    <= '0;
			link_rd_vld_q <= 1'b0;
		end else begin
			if (in_beat) begin
				link_rd_vld_q <= head_in_rng && link_vld_q[head_q[IDX_W-1:0]];
			end
			if (exec_go && do_free) begin
				link_vld_q[idx_q[IDX_W-1:0]] <= 1'b1;
			end
			if (exec_go && do_reinit) begin
				for (int i = 0; i < MAX_BLOCKS; i++) begin
					if (8'(i) < new_active) begin
						link_vld_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q      <= res_status;
			grant_q       <= res_grant;
			offset_q      <= offset_full[15:0];
			blocks_free_q <= res_free;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_index = grant_q;
	assign byte_offset   = offset_q;
	assign blocks_free   = blocks_free_q;

endmodule

`default_nettype wire

### rtl/eflba_checker.sv
`default_nettype none

module eflba_checker
	import eflba_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [1:0]            status,
	input wire logic [7:0]            granted_index,
	input wire logic [15:0]           byte_offset,
	input wire logic [7:0]            blocks_free
);

	// a failed operation never grants a block
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> granted_index == 8'd0 && byte_offset == 16'd0)
		else $error("failed operation shows a grant");

	// block zero always sits at offset zero
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted_index == 8'd0 |-> byte_offset == 16'd0)
		else $error("nonzero offset for block zero");

	// one item in flight: no input beat right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_index)
			&& $stable(byte_offset) && $stable(blocks_free))
		else $error("stalled result beat changed");

endmodule

bind embedded_free_list_block_allocator_core eflba_checker u_eflba_checker (.*);

`default_nettype wire

### sim/block_alloc_checker.sv
module block_alloc_checker
	import eflba_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = 255
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic [7:0]            block_index,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [1:0]            status,
	input  logic [7:0]            granted_index,
	input  logic [15:0]           byte_offset,
	input  logic [7:0]            blocks_free,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  granted;
		logic [15:0] offset;
		logic [7:0]  free_left;
	} grant_t;

	logic [7:0] link_mem [MAX_BLOCKS];
	logic [7:0] head;
	logic [7:0] free_cnt;
	logic [7:0] active_cnt;
	logic [7:0] count_reg;
	logic [8:0] size_reg;
	grant_t     expected_grants [$];
	int         fail_total = 0;

	task automatic rebuild_free_list();
		if (count_reg == 8'd0)
			active_cnt = 8'd1;
		else if (count_reg > MAX_BLOCKS)
			active_cnt = 8'(MAX_BLOCKS);
		else
			active_cnt = count_reg;
		for (int i = 0; i < int'(active_cnt); i++)
			link_mem[i] = 8'(i + 1);
		head = 8'd0;
		free_cnt = active_cnt;
	endtask

	task automatic predict_grant(input logic [1:0] op, input logic [7:0] idx,
		output grant_t res);
		logic [8:0] eff_size;
		res = '0;
		if (size_reg == 9'd0)
			eff_size = 9'd1;
		else if (size_reg > BLOCK_SIZE_MAX)
			eff_size = BLOCK_SIZE_MAX;
		else
			eff_size = size_reg;
		case (op)
			OP_ALLOC: begin
				// a corrupted list may leave the head outside the chunk
				if (free_cnt == 8'd0 || head >= active_cnt) begin
					res.status = STAT_NO_BLOCK;
				end else begin
					res.granted = head;
					res.offset = {8'd0, head} * {7'd0, eff_size};
					head = link_mem[head];
					free_cnt = free_cnt - 8'd1;
				end
			end
			OP_FREE: begin
				if (idx >= active_cnt || free_cnt >= active_cnt) begin
					res.status = STAT_INVALID_FREE;
				end else begin
					link_mem[idx] = head;
					head = idx;
					free_cnt = free_cnt + 8'd1;
				end
			end
			OP_REINIT: rebuild_free_list();
			default: ;
		endcase
		res.free_left = free_cnt;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		grant_t exp_r;
		grant_t got_r;
		if (!arst_n) begin
			count_reg = BLOCK_COUNT_RST;
			size_reg = BLOCK_SIZE_RST;
			for (int i = 0; i < int'(MAX_BLOCKS); i++)
				link_mem[i] = 8'(i + 1);
			rebuild_free_list();
			expected_grants.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_BLOCK_COUNT: count_reg = cfg_wdata[7:0];
					CFG_BLOCK_SIZE:  size_reg = cfg_wdata[8:0];
					default: ;
				endcase
			end
			// result beat is checked before this edge's input beat is predicted
			if (out_valid && out_ready) begin
				got_r = {status, granted_index, byte_offset, blocks_free};
				if (expected_grants.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("unexpected result: status %0d index %0d offset %0d free %0d",
							got_r.status, got_r.granted, got_r.offset, got_r.free_left);
				end else begin
					exp_r = expected_grants.pop_front();
					if (exp_r.status !== got_r.status || exp_r.granted !== got_r.granted ||
						exp_r.offset !== got_r.offset || exp_r.free_left !== got_r.free_left) begin
						fail_total++;
						if (fail_total <= 10)
							$display({"mismatch: expected status %0d index %0d offset %0d free %0d,",
								" got status %0d index %0d offset %0d free %0d"},
								exp_r.status, exp_r.granted, exp_r.offset, exp_r.free_left,
								got_r.status, got_r.granted, got_r.offset, got_r.free_left);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_grant(operation, block_index, exp_r);
				expected_grants.insert(expected_grants.size(), exp_r);
			end
		end
		pending = expected_grants.size();
		fail_count = fail_total;
	end

endmodule

### sim/tb_embedded_free_list_block_allocator_core.sv
module tb_embedded_free_list_block_allocator_core;
	import eflba_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         HOLD_CYCLES = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            operation = OP_ALLOC;
	logic [7:0]            block_index = 8'd0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            status;
	logic [7:0]            granted_index;
	logic [15:0]           byte_offset;
	logic [7:0]            blocks_free;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_reqs = 0;
	int hold_off_served = 0;
	int act_count = 255;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	embedded_free_list_block_allocator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.block_index   (block_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_index (granted_index),
		.byte_offset   (byte_offset),
		.blocks_free   (blocks_free)
	);

	block_alloc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.block_index   (block_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_index (granted_index),
		.byte_offset   (byte_offset),
		.blocks_free   (blocks_free),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// result side: random stalls, or a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_served != hold_off_reqs) begin
				hold_off_served = hold_off_reqs;
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// returns at the edge that accepts the beat; valid stays up for the caller
	task automatic send_op(input logic [1:0] op, input logic [7:0] idx);
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct)
			gap = $urandom_range(4, 1);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		block_index <= idx;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [7:0] count, input logic [8:0] size);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_BLOCK_COUNT;
		cfg_wdata <= {1'b0, count};
		@(posedge clk);
		cfg_addr <= CFG_BLOCK_SIZE;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
		act_count = (count == 8'd0) ? 1 : int'(count);
	endtask

	task automatic random_ops(input int n_items);
		int alloc_pct;
		int r;
		logic [1:0] op;
		logic [7:0] idx;
		alloc_pct = 50;
		for (int k = 0; k < n_items; k++) begin
			// drift between filling and emptying the list
			if ($urandom_range(15) == 0)
				alloc_pct = $urandom_range(80, 20);
			r = $urandom_range(99);
			if (r < 3)
				op = OP_UNUSED;
			else if (r < 7)
				op = OP_REINIT;
			else if (r < 7 + alloc_pct * 93 / 100)
				op = OP_ALLOC;
			else
				op = OP_FREE;
			if ($urandom_range(9) == 0)
				idx = 8'($urandom_range(255));
			else
				idx = 8'($urandom_range(act_count - 1));
			send_op(op, idx);
		end
	endtask

	initial begin
		logic [7:0] counts [8];
		logic [8:0] sizes [8];
		int         idle_mix [4];
		int         stall_mix [4];
		counts = '{8'd3, 8'd255, 8'd0, 8'd8, 8'd2, 8'd200, 8'd1, 8'd16};
		sizes = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd37, 9'd300, 9'd255, 9'd16};
		counts[5] = 8'($urandom_range(255, 1));
		sizes[7] = 9'($urandom_range(256, 1));
		idle_mix = '{0, 51, 0, 33};
		stall_mix = '{0, 0, 51, 33};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: pop, invalid frees, full list, unused code
		send_op(OP_ALLOC, 8'd0);
		send_op(OP_ALLOC, 8'd255);
		send_op(OP_FREE, 8'd255);
		send_op(OP_FREE, 8'd1);
		send_op(OP_FREE, 8'd0);
		send_op(OP_FREE, 8'd0);
		send_op(OP_UNUSED, 8'hAA);
		drain_results();

		// count 0 clamps to one block, size 511 clamps to 256
		write_cfg(8'd0, 9'd511);
		send_op(OP_REINIT, 8'd0);
		send_op(OP_ALLOC, 8'd0);
		send_op(OP_ALLOC, 8'd0);
		send_op(OP_FREE, 8'd1);
		send_op(OP_FREE, 8'd0);
		drain_results();

		// double free of a listed block, then the largest offset
		write_cfg(8'd255, 9'd256);
		send_op(OP_REINIT, 8'd0);
		send_op(OP_ALLOC, 8'd0);
		send_op(OP_FREE, 8'd254);
		send_op(OP_ALLOC, 8'd0);
		send_op(OP_ALLOC, 8'd0);
		send_op(OP_FREE, 8'd254);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mix[p];
			for (int s = 0; s < 2; s++) begin
				drain_results();
				recv_stall_pct <= stall_mix[p];
				write_cfg(counts[2 * p + s], sizes[2 * p + s]);
				send_op(OP_REINIT, 8'd0);
				if (p == 0 && s == 0) begin
					hold_off_reqs <= hold_off_reqs + 1;
					random_ops(20);
				end
				random_ops(76);
			end
		end
		drain_results();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### embedded_free_list_block_allocator_core.f
rtl/eflba_pkg.sv
rtl/embedded_free_list_block_allocator_core.sv
rtl/eflba_checker.sv
sim/block_alloc_checker.sv
sim/tb_embedded_free_list_block_allocator_core.sv
